// ===== src/assert_macros.svh =====
// assertion helpers shared by the queue and back-stage rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define BTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bte_pkg.sv =====
package bte_pkg;

  // widest long-form length field that may be emitted
  localparam int MAX_LENGTH_BYTES = 4;

  localparam int TAG_BYTES     = 4;
  localparam int LEN_BYTES_MAX = (MAX_LENGTH_BYTES < 4) ? MAX_LENGTH_BYTES : 4;
  // tag bytes, length octet and long-form length bytes
  localparam int HDR_MAX       = TAG_BYTES + 1 + LEN_BYTES_MAX;
  localparam int CNT_W         = $clog2(HDR_MAX + 1);
  localparam int IDX_W         = $clog2(HDR_MAX);

  // queue between front and back, depth must be a power of two
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
  localparam logic [6:0] SHORT_LEN_MAX = 7'h7F;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_SIZE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_TAG = 2'd1,
    ST_SMALL   = 2'd2
  } status_e;

  // one classified job: a run of bytes, a size reply or a status
  typedef struct packed {
    kind_e                      kind;
    logic [HDR_MAX-1:0][7:0]    bytes;
    logic [CNT_W-1:0]           nbytes;
    logic [32:0]                total;
    status_e                    status;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic not_empty;
    job_t head;
  } fifo_rd_t;

endpackage

// ===== src/bte_front.sv =====
module bte_front import bte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [31:0] tag_value_i,
  input  logic [31:0] value_length_i,
  input  logic [31:0] buffer_size_i,
  input  logic        size_query_i,
  input  logic [7:0]  data_byte_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [31:0] rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  logic [3:0][7:0]  tb;
  logic [2:0]       n;
  logic             tag_ok;
  logic [3:0]       c;
  logic [32:0]      total;
  logic [CNT_W-1:0] n_ext;
  logic [CNT_W-1:0] c_ext;

  assign tb = tag_value_i;

  // tag length is the position of the highest nonzero byte
  always_comb begin
    if (tb[3] != 8'h00) n = 3'd4;
    else if (tb[2] != 8'h00) n = 3'd3;
    else if (tb[1] != 8'h00) n = 3'd2;
    else if (tb[0] != 8'h00) n = 3'd1;
    else n = 3'd0;
  end

  always_comb begin
    tag_ok = (n != 3'd0);
    if (n > 3'd1) begin
      if (tb[2'(n - 3'd1)][4:0] != 5'h1F) tag_ok = 1'b0;
      if (tb[0][7]) tag_ok = 1'b0;
      for (int i = 1; i < 3; i++) begin
        if ((3'(i) < n - 3'd1) && !tb[i][7]) tag_ok = 1'b0;
      end
    end
  end

  // long-form length byte count
  always_comb begin
    if (value_length_i <= 32'(SHORT_LEN_MAX)) c = 4'd0;
    else if (value_length_i[31:24] != 8'h00) c = 4'd4;
    else if (value_length_i[23:16] != 8'h00) c = 4'd3;
    else if (value_length_i[15:8] != 8'h00) c = 4'd2;
    else c = 4'd1;
  end

  assign total = 33'(n) + 33'(c) + 33'd1 + {1'b0, value_length_i};
  assign n_ext = CNT_W'(n);
  assign c_ext = CNT_W'(c);

  logic [HDR_MAX-1:0][7:0] hdr;

  // header bytes in emission order: tag, then length octets
  always_comb begin
    logic [CNT_W-1:0] k;
    hdr = '0;
    for (int j = 0; j < HDR_MAX; j++) begin
      k = CNT_W'(j) - n_ext;
      if (CNT_W'(j) < n_ext) begin
        hdr[j] = tb[2'(n_ext - CNT_W'(1) - CNT_W'(j))];
      end else if (k == '0) begin
        if (c == 4'd0) hdr[j] = {1'b0, value_length_i[6:0]};
        else hdr[j] = LEN_LONG_FLAG | {4'h0, c};
      end else if (k <= c_ext) begin
        hdr[j] = value_length_i[8*(2'(c_ext - k)) +: 8];
      end
    end
  end

  always_comb begin
    job_o        = '0;
    job_o.kind   = KIND_BYTE;
    job_o.status = ST_OK;
    job_o.nbytes = CNT_W'(1);
    job_o.last   = 1'b1;
    push_o       = 1'b0;
    rem_d        = rem_q;
    if (accept_i) begin
      if (opcode_i == OP_DATA) begin
        if (rem_q != '0) begin
          push_o         = 1'b1;
          job_o.bytes[0] = data_byte_i;
          job_o.last     = (rem_q == 32'd1);
          rem_d          = rem_q - 32'd1;
        end
      end else begin
        push_o = 1'b1;
        rem_d  = '0;
        if (!tag_ok) begin
          job_o.kind   = KIND_STATUS;
          job_o.status = ST_BAD_TAG;
        end else if (size_query_i || (buffer_size_i == '0)) begin
          job_o.kind  = KIND_SIZE;
          job_o.total = total;
        end else if (({1'b0, buffer_size_i} < total) || (c > 4'(MAX_LENGTH_BYTES))) begin
          job_o.kind   = KIND_STATUS;
          job_o.status = ST_SMALL;
        end else begin
          job_o.bytes  = hdr;
          job_o.nbytes = n_ext + c_ext + CNT_W'(1);
          job_o.last   = (value_length_i == '0);
          rem_d        = value_length_i;
        end
      end
    end
  end

endmodule

// ===== src/bte_fifo.sv =====
`include "assert_macros.svh"

module bte_fifo import bte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  job_t     job_i,
  input  logic     pop_i,
  output logic     full_o,
  output fifo_rd_t rd_o
);

  job_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      count_q <= count_q + FCNT_W'(push_i) - FCNT_W'(pop_i);
    end
  end

  assign full_o       = (count_q == FCNT_W'(FIFO_DEPTH));
  assign rd_o.not_empty = (count_q != '0);
  assign rd_o.head    = mem_q[rd_ptr_q];

  `BTE_ASSERT(a_count_range, count_q <= FCNT_W'(FIFO_DEPTH), "queue count beyond depth")
  `BTE_ASSERT_IMP(a_no_overflow, push_i, !full_o || pop_i, "push into full queue")
  `BTE_ASSERT_IMP(a_no_underflow, pop_i, rd_o.not_empty, "pop from empty queue")

endmodule

// ===== src/bte_back.sv =====
`include "assert_macros.svh"

module bte_back import bte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fifo_rd_t    rd_i,
  output logic        fifo_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [32:0] total_size_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic             valid_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             load;
  logic             at_end;
  kind_e            kind_q;
  logic [7:0]       byte_q;
  logic [32:0]      total_q;
  status_e          status_q;
  logic             last_q;

  assign load       = rd_i.not_empty && (!valid_q || pop_i);
  assign at_end     = (CNT_W'(idx_q) == rd_i.head.nbytes - CNT_W'(1));
  assign fifo_pop_o = load && at_end;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = at_end ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) valid_q <= 1'b1;
      else if (pop_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= rd_i.head.kind;
      byte_q   <= (rd_i.head.kind == KIND_BYTE) ? rd_i.head.bytes[idx_q] : 8'h00;
      total_q  <= rd_i.head.total;
      status_q <= rd_i.head.status;
      last_q   <= rd_i.head.last && at_end;
    end
  end

  assign empty_o      = !valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign total_size_o = total_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  `BTE_ASSERT_IMP(a_idx_in_job, rd_i.not_empty, CNT_W'(idx_q) < rd_i.head.nbytes,
                  "byte index past end of job")
  `BTE_ASSERT_IMP(a_single_last, valid_q && (kind_q != KIND_BYTE), last_q,
                  "size or status item without last")

endmodule

// ===== src/ber_tlv_header_encoder.sv =====
// BER tag-length header encoder. Every cycle one item may enter on the push side: a
// header request or a value byte. The front stage validates the tag, sizes the length
// field, tracks the value bytes still pending and queues one job per item; a data byte
// with nothing pending is dropped. The back stage drains the job queue through an output
// register at one result item per cycle while the result side pops, so a value byte
// gives one item and an encoded header gives tag bytes plus length bytes (two to nine
// items), while size replies and status items give one. A taken item is queued and then
// passes through the output register to the result ports. The input side stalls only
// when the two-entry job queue fills, while a header drains or the result side is held.
module ber_tlv_header_encoder import bte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [31:0] tag_value_i,
  input  logic [31:0] value_length_i,
  input  logic [31:0] buffer_size_i,
  input  logic        size_query_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [32:0] total_size_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  job_t     job;
  fifo_rd_t rd;

  assign full = q_full;

  bte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (push && !q_full),
    .opcode_i       (opcode_i),
    .tag_value_i    (tag_value_i),
    .value_length_i (value_length_i),
    .buffer_size_i  (buffer_size_i),
    .size_query_i   (size_query_i),
    .data_byte_i    (data_byte_i),
    .push_o         (q_push),
    .job_o          (job)
  );

  bte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (job),
    .pop_i  (q_pop),
    .full_o (q_full),
    .rd_o   (rd)
  );

  bte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_i         (rd),
    .fifo_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .total_size_o (total_size_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/tb.sv =====
module tb;
  import bte_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  octet;
    logic [32:0] total;
    status_e     status;
    logic        last;
  } res_t;

  // how a stimulus row is checked: through the predictor, no result, or one fixed result
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } chk_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] tag;
    logic [31:0] vlen;
    logic [31:0] bsize;
    logic        query;
    logic [7:0]  dbyte;
    chk_e        chk;
    res_t        fixed;
  } stim_t;

  localparam res_t NONE_RES    = '0;
  localparam res_t BAD_TAG_RES = '{KIND_STATUS, 8'h00, 33'd0, ST_BAD_TAG, 1'b1};
  localparam res_t SMALL_RES   = '{KIND_STATUS, 8'h00, 33'd0, ST_SMALL, 1'b1};
  localparam int   DIR_ROWS    = 24;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        push  = 1'b0;
  logic        pop   = 1'b0;
  logic        full;
  logic        empty;
  stim_t       cur   = '0;
  logic [1:0]  got_kind;
  logic [7:0]  got_byte;
  logic [32:0] got_total;
  logic [1:0]  got_status;
  logic        got_last;

  res_t        out_due_q[$];
  res_t        enc_buf[$];
  logic [31:0] value_left = '0;
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          hold = 0;
  int          sent = 0;
  stim_t       dir_tbl [DIR_ROWS];

  ber_tlv_header_encoder uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .opcode_i      (cur.op),
    .tag_value_i   (cur.tag),
    .value_length_i(cur.vlen),
    .buffer_size_i (cur.bsize),
    .size_query_i  (cur.query),
    .data_byte_i   (cur.dbyte),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (got_kind),
    .out_byte_o    (got_byte),
    .total_size_o  (got_total),
    .status_o      (got_status),
    .last_o        (got_last)
  );

  always #2 clk = ~clk;

  function automatic res_t mk(input kind_e k, input logic [7:0] o, input logic [32:0] t,
                              input status_e st, input logic l);
    return '{k, o, t, st, l};
  endfunction

  // bytes up to the most significant nonzero one
  function automatic int tag_len(input logic [31:0] tag);
    int i;
    for (i = 3; i >= 0; i--) begin
      if (tag[8*i +: 8] != 8'h00) return i + 1;
    end
    return 0;
  endfunction

  function automatic bit tag_ok(input logic [31:0] tag);
    int n, i;
    n = tag_len(tag);
    if (n == 0) return 1'b0;
    if (n == 1) return 1'b1;
    if (tag[8*(n-1) +: 5] != 5'h1F) return 1'b0;
    for (i = 1; i < n - 1; i++) begin
      if (!tag[8*i+7]) return 1'b0;
    end
    return !tag[7];
  endfunction

  // long-form length bytes, zero for short form
  function automatic int len_octets(input logic [31:0] vlen);
    int i;
    if (vlen <= 32'd127) return 0;
    for (i = 3; i >= 0; i--) begin
      if (vlen[8*i +: 8] != 8'h00) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [32:0] enc_size(input logic [31:0] tag, input logic [31:0] vlen);
    return 33'(tag_len(tag)) + 33'(len_octets(vlen)) + 33'd1 + {1'b0, vlen};
  endfunction

  // fills enc_buf with the results one item causes and advances value_left
  function automatic void encode_item(input stim_t s);
    int n, c, i;
    logic [32:0] total;
    enc_buf.delete();
    if (s.op == OP_DATA) begin
      if (value_left != 32'd0) begin
        enc_buf.push_back(mk(KIND_BYTE, s.dbyte, 33'd0, ST_OK, value_left == 32'd1));
        value_left = value_left - 32'd1;
      end
      return;
    end
    value_left = '0;
    if (!tag_ok(s.tag)) begin
      enc_buf.push_back(BAD_TAG_RES);
      return;
    end
    n = tag_len(s.tag);
    c = len_octets(s.vlen);
    total = enc_size(s.tag, s.vlen);
    if (s.query || s.bsize == 32'd0) begin
      enc_buf.push_back(mk(KIND_SIZE, 8'h00, total, ST_OK, 1'b1));
      return;
    end
    if ({1'b0, s.bsize} < total || c > MAX_LENGTH_BYTES) begin
      enc_buf.push_back(SMALL_RES);
      return;
    end
    for (i = n - 1; i >= 0; i--) begin
      enc_buf.push_back(mk(KIND_BYTE, s.tag[8*i +: 8], 33'd0, ST_OK, 1'b0));
    end
    if (c > 0) begin
      enc_buf.push_back(mk(KIND_BYTE, LEN_LONG_FLAG | 8'(c), 33'd0, ST_OK, 1'b0));
      for (i = c - 1; i >= 0; i--) begin
        enc_buf.push_back(mk(KIND_BYTE, s.vlen[8*i +: 8], 33'd0, ST_OK, 1'b0));
      end
    end else begin
      enc_buf.push_back(mk(KIND_BYTE, {1'b0, s.vlen[6:0]}, 33'd0, ST_OK, 1'b0));
    end
    if (s.vlen == 32'd0) enc_buf[enc_buf.size()-1].last = 1'b1;
    value_left = s.vlen;
  endfunction

  task automatic flag_mismatch(input string what, input logic [32:0] got,
                               input logic [32:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] legal_tag();
    int n, i;
    logic [31:0] t;
    n = $urandom_range(1, 4);
    if (n == 1) return {24'd0, 8'($urandom_range(1, 255))};
    t = '0;
    t[8*(n-1) +: 8] = 8'($urandom) | 8'h1F;
    for (i = 1; i < n - 1; i++) begin
      t[8*i +: 8] = 8'($urandom) | 8'h80;
    end
    t[7:0] = 8'($urandom) & 8'h7F;
    return t;
  endfunction

  function automatic stim_t hdr(input logic [31:0] tag, input logic [31:0] vlen,
                                input logic [31:0] bsize, input logic q);
    return '{OP_HEADER, tag, vlen, bsize, q, 8'($urandom), CHK_PREDICT, NONE_RES};
  endfunction

  // header fields of a data item are ignored, so they get noise
  function automatic stim_t dat(input logic [7:0] b);
    return '{OP_DATA, 32'($urandom), 32'($urandom), 32'($urandom), 1'($urandom), b,
             CHK_PREDICT, NONE_RES};
  endfunction

  task automatic send(input stim_t s);
    cur  <= s;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic pace();
    if (!calm && $urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (out_due_q.size() != 0) @(posedge clk);
  endtask

  // legal tag: header, then some or all of its value bytes, at times with one stray byte
  task automatic send_element();
    logic [31:0] tag, vlen, bsize;
    logic [32:0] total, t2;
    logic        q;
    int          r, nd, i;
    tag = legal_tag();
    r = $urandom_range(0, 99);
    if (r < 60)      vlen = $urandom_range(0, 5);
    else if (r < 85) vlen = $urandom_range(6, 300);
    else             vlen = $urandom;
    total = enc_size(tag, vlen);
    q = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t2 = total + 33'($urandom_range(0, 50));
      bsize = t2[32] ? 32'hFFFF_FFFF : t2[31:0];
    end else if (r < 55) begin
      bsize = total[32] ? 32'hFFFF_FFFF : total[31:0];
    end else if (r < 70) begin
      t2 = total - 33'd1;
      bsize = t2[32] ? 32'hFFFF_FFFF : t2[31:0];
    end else if (r < 80) begin
      bsize = '0;
    end else begin
      bsize = $urandom;
      q = 1'b1;
    end
    if (r < 70 && $urandom_range(0, 19) == 0) q = 1'b1;
    send(hdr(tag, vlen, bsize, q));
    pace();
    if (vlen <= 32'd8) nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, vlen) : vlen;
    else nd = $urandom_range(0, 6);
    for (i = 0; i < nd; i++) begin
      send(dat(8'($urandom)));
      pace();
    end
    if ($urandom_range(0, 9) == 0) begin
      send(dat(8'($urandom)));
      pace();
    end
  endtask

  task automatic send_noise();
    logic [31:0] tag;
    int r, i;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send(hdr($urandom, ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 200)) : $urandom,
               ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 300)) : $urandom,
               1'($urandom)));
      pace();
    end else if (r < 80) begin
      // legal tag with one bit flipped
      tag = legal_tag() ^ (32'd1 << $urandom_range(0, 31));
      send(hdr(tag, $urandom_range(0, 4), 32'hFFFF_FFFF, 1'b0));
      pace();
      for (i = 0; i < $urandom_range(0, 2); i++) begin
        send(dat(8'($urandom)));
        pace();
      end
    end else begin
      for (i = 0; i < $urandom_range(1, 3); i++) begin
        send(dat(8'($urandom)));
        pace();
      end
    end
  endtask

  always @(posedge clk) begin : pop_ctl
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold != 0) begin
      pop  <= 1'b0;
      hold <= hold - 1;
    end else begin
      pop <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) hold <= gap_len();
    end
  end

  always @(posedge clk) begin : take_in
    if (rst_n && push && !full) begin
      encode_item(cur);
      case (cur.chk)
        CHK_PREDICT: foreach (enc_buf[k]) out_due_q.push_back(enc_buf[k]);
        CHK_ONE:     out_due_q.push_back(cur.fixed);
        default:     ;
      endcase
    end
  end

  always @(posedge clk) begin : check_out
    res_t want;
    if (rst_n && pop && !empty) begin
      if (out_due_q.size() == 0) begin
        flag_mismatch("result with nothing due", {25'd0, got_byte}, 33'd0);
      end else begin
        want = out_due_q.pop_front();
        if (got_kind !== want.kind) flag_mismatch("kind", 33'(got_kind), 33'(want.kind));
        if (got_byte !== want.octet) flag_mismatch("out_byte", 33'(got_byte), 33'(want.octet));
        if (got_total !== want.total) flag_mismatch("total_size", got_total, want.total);
        if (got_status !== want.status) begin
          flag_mismatch("status", 33'(got_status), 33'(want.status));
        end
        if (got_last !== want.last) flag_mismatch("last", 33'(got_last), 33'(want.last));
      end
    end
  end

  initial begin : stimulus
    int i;
    dir_tbl = '{
      // stray data right after reset
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'hA5, CHK_NONE, NONE_RES},
      // zero tag, all-ones tag, bad escape byte, bad middle byte
      '{OP_HEADER, 32'h0000_0000, 32'd5, 32'd100, 1'b0, 8'h00, CHK_ONE, BAD_TAG_RES},
      '{OP_HEADER, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 8'h00, CHK_ONE, BAD_TAG_RES},
      '{OP_HEADER, 32'h0000_1E05, 32'd1, 32'd100, 1'b0, 8'h00, CHK_ONE, BAD_TAG_RES},
      '{OP_HEADER, 32'h001F_0005, 32'd1, 32'd100, 1'b0, 8'h00, CHK_ONE, BAD_TAG_RES},
      // size queries: zero buffer, then the flag with the largest total
      '{OP_HEADER, 32'h0000_001E, 32'd0, 32'd0, 1'b0, 8'h00, CHK_ONE,
        '{KIND_SIZE, 8'h00, 33'd2, ST_OK, 1'b1}},
      '{OP_HEADER, 32'h7FFF_FF7F, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 8'h00, CHK_ONE,
        '{KIND_SIZE, 8'h00, 33'h1_0000_0008, ST_OK, 1'b1}},
      // buffer too small: all-ones against the largest total, then one short
      '{OP_HEADER, 32'h7FFF_FF7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00, CHK_ONE, SMALL_RES},
      '{OP_HEADER, 32'h0000_0002, 32'd10, 32'd11, 1'b0, 8'h00, CHK_ONE, SMALL_RES},
      // exact fit, then its value bytes and one stray
      '{OP_HEADER, 32'h0000_0002, 32'd3, 32'd5, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'hFF, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h5A, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h33, CHK_NONE, NONE_RES},
      // empty value
      '{OP_HEADER, 32'h0000_0005, 32'd0, 32'd2, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      // longest header, then headers that cut runs short
      '{OP_HEADER, 32'h7FFF_FF7F, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0, 8'h00, CHK_PREDICT,
        NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h11, CHK_PREDICT, NONE_RES},
      '{OP_HEADER, 32'h001F_8101, 32'd128, 32'h0000_0200, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'hC3, CHK_PREDICT, NONE_RES},
      '{OP_HEADER, 32'h0000_0010, 32'd127, 32'd129, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_HEADER, 32'h0000_1F7F, 32'd256, 32'hFFFF_FFFF, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_HEADER, 32'h0000_1F00, 32'd2, 32'd6, 1'b0, 8'h00, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h80, CHK_PREDICT, NONE_RES},
      '{OP_DATA, 32'h0, 32'd0, 32'd0, 1'b0, 8'h7E, CHK_PREDICT, NONE_RES}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < DIR_ROWS; i++) begin
      send(dir_tbl[i]);
      pace();
    end
    drain();
    while (sent < 100) begin
      if ($urandom_range(0, 6) == 0) calm = !calm;
      if ($urandom_range(0, 99) < 70) send_element();
      else send_noise();
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bte_pkg.sv
src/bte_front.sv
src/bte_fifo.sv
src/bte_back.sv
src/ber_tlv_header_encoder.sv
test/tb.sv
